// File: rtl/hlt_pkg.sv
`timescale 1ns / 1ps

package hlt_pkg;

  localparam logic [1:0] STATUS_UPDATED = 2'd0;
  localparam logic [1:0] STATUS_JOINED  = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_REPORT  = 2'd3;

  localparam int SUM_W   = 39;
  localparam int INDEX_W = 7;
  localparam int ALIVE_W = 8;

  localparam int CFG_ADDR_W = 3;
  localparam logic CFG_IDX_TIMEOUT = 1'b0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5;

  typedef struct packed {
    logic        action;
    logic [63:0] name_tag;
    logic [31:0] sender_ip;
    logic [31:0] total_mb;
    logic [31:0] free_mb;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [INDEX_W-1:0] node_index;
    logic [ALIVE_W-1:0] alive_count;
    logic [SUM_W-1:0]   pooled_total_mb;
    logic [SUM_W-1:0]   pooled_free_mb;
  } out_item_t;

  typedef struct packed {
    logic [63:0] name;
    logic [31:0] ip;
    logic [31:0] total;
    logic [31:0] free;
    logic [31:0] seen_sec;
  } entry_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } hlt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } hlt_sts_t;

endpackage

// File: rtl/hlt_ctrl.sv
`timescale 1ns / 1ps

module hlt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  hlt_pkg::hlt_sts_t sts,
  output hlt_pkg::hlt_cmd_t cmd
);
  import hlt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/hlt_dp.sv
`timescale 1ns / 1ps

module hlt_dp #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  hlt_pkg::in_item_t  in_item,
  input  logic [15:0]        timeout,
  input  hlt_pkg::hlt_cmd_t  cmd,
  output hlt_pkg::hlt_sts_t  sts,
  output logic               out_valid,
  input  logic               out_stall,
  output hlt_pkg::out_item_t out_item
);
  import hlt_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  entry_t mem [TABLE_DEPTH];

  logic [CW-1:0] cnt;
  logic [31:0]   now;

  in_item_t      it;
  logic [CW-1:0] scan_idx;
  logic          issue;
  entry_t        rd_data;
  logic          rd_vld;
  logic [IW-1:0] rd_idx;
  logic          hit_found;
  logic [IW-1:0] hit_slot;

  logic          s2_vld;
  logic          s2_alive;
  logic [31:0]   s2_tot;
  logic [31:0]   s2_fre;

  logic [ALIVE_W-1:0] alive;
  logic [SUM_W-1:0]   sum_t;
  logic [SUM_W-1:0]   sum_f;
  logic [SUM_W:0]     add_t;
  logic [SUM_W:0]     add_f;
  logic [31:0]        age;

  logic          full;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic [IW-1:0] slot;
  logic [IW+INDEX_W-1:0] slot_ext;
  out_item_t     res;

  assign issue = cmd.scan && (scan_idx < cnt) && !hit_found;
  assign sts.scan_done = !rd_vld && !s2_vld && ((scan_idx >= cnt) || hit_found);
  assign sts.out_free  = !out_valid || !out_stall;

  assign age   = now - rd_data.seen_sec;
  assign add_t = {1'b0, sum_t} + (SUM_W + 1)'(s2_tot);
  assign add_f = {1'b0, sum_f} + (SUM_W + 1)'(s2_fre);

  assign full    = (cnt == CW'(TABLE_DEPTH));
  assign wr_addr = hit_found ? hit_slot : cnt[IW-1:0];
  assign wr_en   = cmd.finish && !it.action && (hit_found || !full);
  assign slot    = wr_addr;
  assign slot_ext = {{INDEX_W{1'b0}}, slot};

  always_comb begin
    wr_data.name     = it.name_tag;
    wr_data.ip       = it.sender_ip;
    wr_data.total    = it.total_mb;
    wr_data.free     = it.free_mb;
    wr_data.seen_sec = now;
  end

  always_comb begin
    res = '0;
    if (it.action) begin
      res.status          = STATUS_REPORT;
      res.alive_count     = alive;
      res.pooled_total_mb = sum_t;
      res.pooled_free_mb  = sum_f;
    end else if (hit_found) begin
      res.status     = STATUS_UPDATED;
      res.node_index = slot_ext[INDEX_W-1:0];
    end else if (!full) begin
      res.status     = STATUS_JOINED;
      res.node_index = slot_ext[INDEX_W-1:0];
    end else begin
      res.status = STATUS_FULL;
    end
  end

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[scan_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      it <= in_item;
    end
    if (issue) begin
      rd_idx <= scan_idx[IW-1:0];
    end
    if (rd_vld) begin
      s2_alive <= (age <= {16'd0, timeout});
      s2_tot   <= rd_data.total;
      s2_fre   <= rd_data.free;
    end
    if (cmd.finish) begin
      out_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      now       <= '0;
      scan_idx  <= '0;
      rd_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      hit_found <= 1'b0;
      hit_slot  <= '0;
      alive     <= '0;
      sum_t     <= '0;
      sum_f     <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= issue;
      s2_vld <= rd_vld && it.action;
      if (cmd.start) begin
        scan_idx  <= '0;
        hit_found <= 1'b0;
        alive     <= '0;
        sum_t     <= '0;
        sum_f     <= '0;
        if (in_item.action) begin
          now <= now + 32'd1;
        end
      end else begin
        if (issue) begin
          scan_idx <= scan_idx + CW'(1);
        end
        if (rd_vld && !it.action && !hit_found &&
            (rd_data.name == it.name_tag) && (rd_data.ip == it.sender_ip)) begin
          hit_found <= 1'b1;
          hit_slot  <= rd_idx;
        end
        if (s2_vld && s2_alive) begin
          if (alive != '1) begin
            alive <= alive + ALIVE_W'(1);
          end
          sum_t <= add_t[SUM_W] ? '1 : add_t[SUM_W-1:0];
          sum_f <= add_f[SUM_W] ? '1 : add_f[SUM_W-1:0];
        end
      end
      if (wr_en && !hit_found) begin
        cnt <= cnt + CW'(1);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/heartbeat_liveness_table.sv
// A heartbeat's scan stops at the slot that it hits; a miss and a tick scan every filled entry,
// and an empty table is not scanned. A stalled output delays the loading of the result.
// The next item is taken only after the result is loaded, as the scan reads one entry a cycle
// through the single registered read port of the entry memory.
// Reset (synchronous, active high) empties the table by its fill count, zeroes the seconds
`timescale 1ns / 1ps

// counter, sets the timeout to 5 and empties the output; the memory itself is not cleared.
module heartbeat_liveness_table #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  hlt_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output hlt_pkg::out_item_t                out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hlt_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import hlt_pkg::*;

  hlt_cmd_t    cmd;
  hlt_sts_t    sts;
  logic [15:0] timeout;

  // The only register sits at word index 0. Bit 2 of the byte address selects the word;
  // writes to any other word are ignored and read back as zero.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_TIMEOUT) ? {16'd0, timeout} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_TIMEOUT)) begin
      timeout <= pwdata[15:0];
    end
  end

  // The controller sequences start, scan and finish; the datapath owns the table,
  // the scan pipeline and the output register.
  hlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hlt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .timeout   (timeout),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // At most one command is issued in any cycle.
  assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("controller issued more than one command");

  // A result is only loaded when the output register can take it.
  assert property (@(posedge clk) disable iff (rst) cmd.finish |-> sts.out_free)
    else $error("result loaded over a pending result");

  // Once an item is taken the block is busy with it in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting an item");

  // A result appears only after the controller finished an item.
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(cmd.finish))
    else $error("output became valid without a finished item");

endmodule
